FILE: rtl/core/mt_pkg.sv
// Shared types and constants for the Mersenne Twister generator.
// Used by mt_engine and mersenne_twister_prng; no dependencies.
`timescale 1ns / 1ps

package mt_pkg;

  // state array and twist geometry
  localparam int STATE_WORDS  = 624;
  localparam int SHIFT_OFFSET = 397;
  localparam int ADDR_W       = $clog2(STATE_WORDS);

  // key buffer sizing
  localparam int MAX_KEY_WORDS  = 16;
  localparam int KEY_IDX_W      = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
  localparam int KEY_CNT_W      = $clog2(MAX_KEY_WORDS + 1);
  localparam int BOOT_KEY_WORDS = 4;
  localparam int BOOT_IDX_W     = $clog2(BOOT_KEY_WORDS);
  // length field must also hold the boot key length
  localparam int KEY_LEN_W      = (KEY_CNT_W > BOOT_IDX_W + 1) ? KEY_CNT_W : BOOT_IDX_W + 1;

  // algorithm constants
  localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
  localparam logic [31:0] HIGH_BIT     = 32'h80000000;
  localparam logic [31:0] LIN_MULT     = 32'd1812433253;
  localparam logic [31:0] ARR_SEED     = 32'd19650218;
  localparam logic [31:0] ARR_MULT1    = 32'd1664525;
  localparam logic [31:0] ARR_MULT2    = 32'd1566083941;
  localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
  localparam logic [31:0] TEMPER_C     = 32'hefc60000;

  // key applied after reset
  localparam logic [31:0] BOOT_KEY [BOOT_KEY_WORDS] = '{
    32'h00000123, 32'h00000234, 32'h00000345, 32'h00000456
  };

  // request kinds carried on tuser
  typedef enum logic [1:0] {
    FUNC_SEED = 2'd0,
    FUNC_KEY  = 2'd1,
    FUNC_DRAW = 2'd2
  } mt_func_e;

  // command from the stream front end to the engine
  typedef struct packed {
    logic                 seed_lin;
    logic                 seed_arr;
    logic                 draw;
    logic [31:0]          seed;
    logic [KEY_LEN_W-1:0] key_len;
  } mt_cmd_t;

  // one drawn word handed to the output register
  typedef struct packed {
    logic        valid;
    logic [31:0] word;
  } mt_res_t;

endpackage

FILE: rtl/core/mt_engine.sv
// State memory and sequencer: linear seeding, array seeding and draws.
// Depends on mt_pkg; key words come from the key buffer in the top level.
`timescale 1ns / 1ps

module mt_engine
  import mt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mt_cmd_t              cmd_i,
  output logic                 busy_o,
  output logic [KEY_IDX_W-1:0] key_idx_o,
  input  logic [31:0]          key_data_i,
  input  logic                 res_ready_i,
  output mt_res_t              res_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_LIN_MUL = 4'd1;
  localparam logic [3:0] S_LIN_WR  = 4'd2;
  localparam logic [3:0] S_ARR_RD  = 4'd3;
  localparam logic [3:0] S_ARR_WR  = 4'd4;
  localparam logic [3:0] S_ARR_END = 4'd5;
  localparam logic [3:0] S_DR1     = 4'd6;
  localparam logic [3:0] S_DR2     = 4'd7;
  localparam logic [3:0] S_DR3     = 4'd8;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STATE_WORDS - 1);
  localparam logic [ADDR_W-1:0] WRAP_LIM  = ADDR_W'(STATE_WORDS - SHIFT_OFFSET);
  localparam logic [ADDR_W-1:0] FAR_OFS   = ADDR_W'(SHIFT_OFFSET);
  localparam logic [ADDR_W-1:0] ONE_ADDR  = ADDR_W'(1);

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  logic [3:0]           state_q;
  logic [31:0]          p_q;
  logic [ADDR_W-1:0]    n_q, i_q, k_q, pos_q;
  logic [KEY_LEN_W-1:0] j_q, len_q;
  logic                 arr_q, boot_q, ph2_q;
  logic [31:0]          prod_q, add_q, rdata_q;
  logic                 hi_q;
  logic [30:0]          lo_q;

  logic                 mem_we, mem_re;
  logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
  logic [31:0]          mem_wdata;
  logic [31:0]          mul_x, mul_k, prod_d;
  logic [31:0]          lin_val, arr_val, twist_val, key_val, y_word;
  logic [ADDR_W-1:0]    pos_nxt, far_addr;
  logic [31:0]          state_mem [STATE_WORDS];

  // shared multiplier and datapath values
  assign mul_x   = p_q ^ (p_q >> 30);
  assign prod_d  = mul_x * mul_k;
  assign lin_val = prod_q + 32'(n_q);
  assign arr_val = (rdata_q ^ prod_q) + add_q;
  assign y_word  = {hi_q, lo_q};
  assign twist_val = rdata_q ^ (y_word >> 1) ^ (y_word[0] ? TWIST_MATRIX : 32'd0);
  assign key_val = boot_q ? BOOT_KEY[j_q[BOOT_IDX_W-1:0]] : key_data_i;
  assign key_idx_o = j_q[KEY_IDX_W-1:0];

  // neighbor addresses for the word being twisted
  assign pos_nxt  = (pos_q == LAST_ADDR) ? '0 : pos_q + ONE_ADDR;
  assign far_addr = (pos_q >= WRAP_LIM) ? pos_q - WRAP_LIM : pos_q + FAR_OFS;

  assign busy_o = (state_q != S_IDLE);

  // memory port control per state
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = i_q;
    mem_wdata   = arr_val;
    mem_re      = 1'b0;
    mem_raddr   = pos_q;
    mul_k       = LIN_MULT;
    res_o.valid = 1'b0;
    res_o.word  = temper(twist_val);
    case (state_q)
      S_IDLE: begin
        if (cmd_i.seed_lin || cmd_i.seed_arr) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = cmd_i.seed_lin ? cmd_i.seed : ARR_SEED;
        end else if (cmd_i.draw) begin
          mem_re    = 1'b1;
          mem_raddr = pos_q;
        end
      end
      S_LIN_MUL: begin
        mul_k = LIN_MULT;
      end
      S_LIN_WR: begin
        mem_we    = 1'b1;
        mem_waddr = n_q;
        mem_wdata = lin_val;
      end
      S_ARR_RD: begin
        mem_re    = 1'b1;
        mem_raddr = i_q;
        mul_k     = ph2_q ? ARR_MULT2 : ARR_MULT1;
      end
      S_ARR_WR: begin
        mem_we    = 1'b1;
        mem_waddr = i_q;
        mem_wdata = arr_val;
      end
      S_ARR_END: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = HIGH_BIT;
      end
      S_DR1: begin
        mem_re    = 1'b1;
        mem_raddr = pos_nxt;
      end
      S_DR2: begin
        mem_re    = 1'b1;
        mem_raddr = far_addr;
      end
      S_DR3: begin
        mem_we      = res_ready_i;
        mem_waddr   = pos_q;
        mem_wdata   = twist_val;
        res_o.valid = res_ready_i;
      end
      default: begin
      end
    endcase
  end

  // state memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      state_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= state_mem[mem_raddr];
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_LIN_MUL || state_q == S_ARR_RD) begin
      prod_q <= prod_d;
    end
    if (state_q == S_ARR_RD) begin
      add_q <= ph2_q ? (32'd0 - 32'(i_q)) : key_val + 32'(j_q);
    end
    if (state_q == S_DR1) begin
      hi_q <= rdata_q[31];
    end
    if (state_q == S_DR2) begin
      lo_q <= rdata_q[30:0];
    end
  end

  // sequencer; reset starts array seeding with the boot key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LIN_MUL;
      p_q     <= ARR_SEED;
      n_q     <= ONE_ADDR;
      arr_q   <= 1'b1;
      boot_q  <= 1'b1;
      len_q   <= KEY_LEN_W'(BOOT_KEY_WORDS);
      i_q     <= ONE_ADDR;
      j_q     <= '0;
      k_q     <= '0;
      ph2_q   <= 1'b0;
      pos_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_i.seed_lin || cmd_i.seed_arr) begin
            p_q     <= cmd_i.seed_lin ? cmd_i.seed : ARR_SEED;
            n_q     <= ONE_ADDR;
            arr_q   <= cmd_i.seed_arr;
            boot_q  <= 1'b0;
            len_q   <= cmd_i.key_len;
            state_q <= S_LIN_MUL;
          end else if (cmd_i.draw) begin
            state_q <= S_DR1;
          end
        end
        S_LIN_MUL: begin
          state_q <= S_LIN_WR;
        end
        S_LIN_WR: begin
          if (n_q == LAST_ADDR) begin
            pos_q <= '0;
            if (arr_q) begin
              // key mixing starts at word 1, taking the array seed as the word before it
              p_q     <= ARR_SEED;
              i_q     <= ONE_ADDR;
              j_q     <= '0;
              k_q     <= '0;
              ph2_q   <= 1'b0;
              state_q <= S_ARR_RD;
            end else begin
              p_q     <= lin_val;
              state_q <= S_IDLE;
            end
          end else begin
            p_q     <= lin_val;
            n_q     <= n_q + ONE_ADDR;
            state_q <= S_LIN_MUL;
          end
        end
        S_ARR_RD: begin
          state_q <= S_ARR_WR;
        end
        S_ARR_WR: begin
          p_q <= arr_val;
          i_q <= (i_q == LAST_ADDR) ? ONE_ADDR : i_q + ONE_ADDR;
          if (!ph2_q) begin
            j_q <= (j_q + KEY_LEN_W'(1) == len_q) ? '0 : j_q + KEY_LEN_W'(1);
          end
          // key mixing pass runs one step per state word, the second pass one fewer
          if (!ph2_q && k_q == LAST_ADDR) begin
            ph2_q   <= 1'b1;
            k_q     <= '0;
            state_q <= S_ARR_RD;
          end else if (ph2_q && k_q == LAST_ADDR - ONE_ADDR) begin
            state_q <= S_ARR_END;
          end else begin
            k_q     <= k_q + ONE_ADDR;
            state_q <= S_ARR_RD;
          end
        end
        S_ARR_END: begin
          pos_q   <= '0;
          state_q <= S_IDLE;
        end
        S_DR1: begin
          state_q <= S_DR2;
        end
        S_DR2: begin
          state_q <= S_DR3;
        end
        S_DR3: begin
          // hold until the output register can take the word
          if (res_ready_i) begin
            pos_q   <= pos_nxt;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/mersenne_twister_prng.sv
// Top level of the MT19937 generator: stream ports, key buffer, output register.
// Depends on mt_pkg and mt_engine.
`timescale 1ns / 1ps

// MT19937 pseudo-random generator. Requests arrive on the s_axis side with the
// kind on tuser: seed with one word, key word (tlast marks the final one and
// starts array seeding), or draw. Each draw returns one tempered word on the
// m_axis side. The 624-word state sits in a synchronous memory with one write
// port and one registered read port; each word is twisted when it is drawn,
// with three memory reads (the word, its neighbor and the word 397 places on)
// and the write-back, which the sequencer issues one at a time. A seed request
// runs a multiply step and a write step per state word. A non-final key word is
// only stored; a final one runs linear seeding then two passes over the state,
// with a read step and a write step per word. After reset the block seeds
// itself with the fixed four-word key and accepts no request until that
// seeding is done. Key words beyond the 16-word buffer are dropped. The output
// register lets the next request enter while a drawn word waits to be taken.

module mersenne_twister_prng
  import mt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // seed_value [31:0], key_word [63:32]
  input  logic [1:0]  s_axis_tuser_i,   // func [1:0]
  input  logic        s_axis_tlast_i,   // key_last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // random_word [31:0]
);

  logic                 busy;
  logic                 in_fire;
  mt_func_e             func;
  mt_cmd_t              cmd;
  mt_res_t              res;
  logic                 res_ready;
  logic [KEY_IDX_W-1:0] key_idx;
  logic [KEY_CNT_W-1:0] key_count_q, key_count_d;
  logic                 key_store_en;
  logic [31:0]          key_store [MAX_KEY_WORDS];
  logic                 out_valid_q;
  logic [31:0]          out_data_q;

  assign s_axis_tready_o = !busy;
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign func    = mt_func_e'(s_axis_tuser_i);

  // decode a request into an engine command
  always_comb begin
    cmd          = '0;
    cmd.seed     = s_axis_tdata_i[31:0];
    key_store_en = 1'b0;
    key_count_d  = key_count_q;
    if (in_fire) begin
      case (func)
        FUNC_SEED: begin
          cmd.seed_lin = 1'b1;
        end
        FUNC_KEY: begin
          if (key_count_q < KEY_CNT_W'(MAX_KEY_WORDS)) begin
            key_store_en = 1'b1;
            key_count_d  = key_count_q + KEY_CNT_W'(1);
          end
          if (s_axis_tlast_i) begin
            cmd.seed_arr = 1'b1;
            cmd.key_len  = KEY_LEN_W'(key_count_d);
            key_count_d  = '0;
          end
        end
        FUNC_DRAW: begin
          cmd.draw = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // key buffer
  always_ff @(posedge clk_i) begin
    if (key_store_en) begin
      key_store[key_count_q[KEY_IDX_W-1:0]] <= s_axis_tdata_i[63:32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= '0;
    end else begin
      key_count_q <= key_count_d;
    end
  end

  mt_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .busy_o      (busy),
    .key_idx_o   (key_idx),
    .key_data_i  (key_store[key_idx]),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_data_q <= res.word;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
